FILE: src/piecewise_polynomial_evaluator_defines.svh
// assertion macros for the piecewise polynomial evaluator
`ifndef PIECEWISE_POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define PIECEWISE_POLYNOMIAL_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PPE_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PPE_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("%m failed");
`else
`define PPE_ASSERT_IMPL(label, clk, rst_n, prop)
`define PPE_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

FILE: src/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// types and constants shared by the piecewise polynomial evaluator
// ----------------------------------------------------------------------------
package ppe_pkg;
	localparam int MaxSegments = 256;
	localparam int MaxCoefs    = 4;
	localparam int FracBits    = 16;

	localparam logic [1:0] OP_WR_BREAK = 2'd0;
	localparam logic [1:0] OP_WR_COEF  = 2'd1;
	localparam logic [1:0] OP_EVAL     = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BELOW = 3'd1;
	localparam logic [2:0] ST_ABOVE = 3'd2;
	localparam logic [2:0] ST_SAT   = 3'd3;
	localparam logic [2:0] ST_WACK  = 3'd4;

	localparam logic [0:0] REG_POLY_ORDER    = 1'd0;
	localparam logic [0:0] REG_SEGMENT_COUNT = 1'd1;

	typedef struct packed {
		logic [1:0]         op;
		logic [8:0]         table_slot;
		logic [1:0]         coef_power;
		logic signed [31:0] write_value;
		logic signed [31:0] query_x;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] poly_value;
		logic signed [31:0] first_deriv;
		logic signed [31:0] second_deriv;
		logic [7:0]         segment_used;
	} out_item_t;
endpackage

FILE: src/piecewise_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// piecewise_polynomial_evaluator
// breakpoint and coefficient memories with a horner sequencer for value,
// first and second derivative
// ----------------------------------------------------------------------------
// channel  direction  handshake        payload
// in       input      in_valid/stall   ppe_pkg::in_item_t
// out      output     out_valid/stall  ppe_pkg::out_item_t
// cfg      input      cfg_we           cfg_index, cfg_data
//
// a write item is acknowledged with a ST_WACK result; an evaluation on a cache hit
// runs the range and cache checks, then dx, then the first horner step (coefficient
// read, add) and each later one (coefficient read, three products on one multiplier, add).
// a cache miss adds a search over the breakpoints; out of range ends in the range checks.
// one item at a time; a held result stalls the input while out_stall is high.
// memories are not cleared by reset; reset returns control to idle and sets config to order 3, count 1.
module piecewise_polynomial_evaluator #(
	parameter int MAX_SEGMENTS = ppe_pkg::MaxSegments,
	parameter int MAX_COEFS    = ppe_pkg::MaxCoefs,
	parameter int FRAC_BITS    = ppe_pkg::FracBits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ppe_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ppe_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [8:0]          cfg_data
);
	import ppe_pkg::*;
`include "piecewise_polynomial_evaluator_defines.svh"

	localparam int SW = $clog2(MAX_SEGMENTS);
	localparam int BW = $clog2(MAX_SEGMENTS + 1);
	localparam int CW = $clog2(MAX_COEFS);
	localparam int NW = $clog2(MAX_SEGMENTS + 1);
	localparam int KW = $clog2(MAX_COEFS);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RDN   = 11'b00000000010,
		S_CHKN  = 11'b00000000100,
		S_CHK0  = 11'b00000001000,
		S_CHKC  = 11'b00000010000,
		S_CHKC1 = 11'b00000100000,
		S_SRCH  = 11'b00001000000,
		S_DX    = 11'b00010000000,
		S_CRD   = 11'b00100000000,
		S_MUL   = 11'b01000000000,
		S_ADD   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [1:0] ord_cfg_q;
	logic [8:0] cnt_cfg_q;
	logic [SW-1:0] cache_q, seg_q;
	logic signed [31:0] x_q;
	logic signed [32:0] dx_q;
	logic [BW-1:0] k_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] ord_q, i_q;
	logic signed [31:0] y0_q, y1_q, y2_q, c_q;
	logic signed [64:0] p0_q, p1_q, p2_q;
	logic flag_q, wr_q, hit_q;
	logic [1:0] mph_q;

	logic signed [31:0] break_mem [MAX_SEGMENTS+1];
	logic signed [31:0] coef_mem [MAX_SEGMENTS*MAX_COEFS];
	logic [BW-1:0] b_addr;
	logic signed [31:0] b_rd_q, c_rd_q;
	logic [$clog2(MAX_SEGMENTS*MAX_COEFS)-1:0] c_addr;

	out_item_t res_q;
	logic res_v_q;

	assign in_stall  = (state_q != S_IDLE) || wr_q || (res_v_q && out_stall);
	assign out_valid = res_v_q;
	assign out_item  = res_q;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	logic wr_acc;
	assign wr_acc = in_acc && (in_item.op == OP_WR_BREAK || in_item.op == OP_WR_COEF);

	// effective order and count
	logic [KW-1:0] ord_eff;
	logic [NW-1:0] n_eff;
	always_comb begin
		ord_eff = (ord_cfg_q == 2'd0) ? KW'(1) :
			(32'(ord_cfg_q) > MAX_COEFS - 1) ? KW'(MAX_COEFS - 1) : KW'(ord_cfg_q);
		n_eff = (cnt_cfg_q == 9'd0) ? NW'(1) :
			(32'(cnt_cfg_q) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS) : NW'(cnt_cfg_q);
	end

	// breakpoint read address, data arrives in the following state
	always_comb begin
		unique case (state_q)
			S_IDLE:  b_addr = BW'(0);
			S_RDN:   b_addr = n_q;
			S_CHKN:  b_addr = BW'(0);
			S_CHK0:  b_addr = BW'(cache_q);
			S_CHKC:  b_addr = BW'(cache_q) + BW'(1);
			S_CHKC1: b_addr = k_q;
			S_SRCH:  b_addr = k_q;
			default: b_addr = BW'(seg_q);
		endcase
		if (state_q == S_IDLE) b_addr = BW'(n_eff);
	end
	assign c_addr = {seg_q, i_q[CW-1:0]};

	// memories
	always_ff @(posedge clk) begin
		if (in_acc && in_item.op == OP_WR_BREAK && 32'(in_item.table_slot) <= MAX_SEGMENTS)
			break_mem[in_item.table_slot[BW-1:0]] <= in_item.write_value;
		b_rd_q <= break_mem[b_addr];
	end
	always_ff @(posedge clk) begin
		if (in_acc && in_item.op == OP_WR_COEF && 32'(in_item.table_slot) < MAX_SEGMENTS
			&& 32'(in_item.coef_power) < MAX_COEFS)
			coef_mem[{in_item.table_slot[SW-1:0], in_item.coef_power[CW-1:0]}]
				<= in_item.write_value;
		c_rd_q <= coef_mem[c_addr];
	end

	// horner arithmetic helpers
	function automatic logic signed [31:0] sat(input logic signed [65:0] v, inout logic f);
		if (v > 66'sd2147483647) begin f = 1'b1; return 32'sh7fffffff; end
		if (v < -66'sd2147483648) begin f = 1'b1; return 32'sh80000000; end
		return v[31:0];
	endfunction

	logic [KW+1:0] r, k1, k2;
	logic signed [65:0] t0, t1, t2;
	always_comb begin
		r  = (KW+2)'(ord_q) - (KW+2)'(i_q);
		k1 = r;
		k2 = (r == 0) ? '0 : (KW+2)'(r * (r - 1'b1));
		t0 = 66'(c_q);
		t1 = 66'(c_q) * $signed({1'b0, k1});
		t2 = 66'(c_q) * $signed({1'b0, k2});
	end

	logic signed [64:0] mul_a, mul_r;
	always_comb begin
		unique case (mph_q)
			2'd0:    mul_a = 65'(y0_q);
			2'd1:    mul_a = 65'(y1_q);
			default: mul_a = 65'(y2_q);
		endcase
		mul_r = mul_a * 65'(dx_q);
	end

	logic signed [31:0] ny0, ny1, ny2;
	logic nf;
	always_comb begin
		nf  = flag_q;
		ny0 = y0_q; ny1 = y1_q; ny2 = y2_q;
		if (i_q == '0) begin
			ny0 = sat(t0, nf);
			if (k1 != 0) ny1 = sat(t1, nf);
			if (k2 != 0) ny2 = sat(t2, nf);
		end else begin
			ny0 = sat(66'(p0_q >>> FRAC_BITS) + t0, nf);
			if (k1 != 0) ny1 = sat(66'(p1_q >>> FRAC_BITS) + t1, nf);
			if (k2 != 0) ny2 = sat(66'(p2_q >>> FRAC_BITS) + t2, nf);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ord_cfg_q <= 2'd3;
			cnt_cfg_q <= 9'd1;
			cache_q   <= '0;
			res_v_q   <= 1'b0;
			wr_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_POLY_ORDER) ord_cfg_q <= cfg_data[1:0];
				else cnt_cfg_q <= cfg_data;
			end
			if (res_v_q && !out_stall && !wr_acc) res_v_q <= 1'b0;
			wr_q <= wr_acc;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						x_q <= in_item.query_x;
						n_q <= n_eff;
						ord_q <= ord_eff;
						if (in_item.op == OP_WR_BREAK || in_item.op == OP_WR_COEF) begin
							cache_q <= '0;
							res_v_q <= 1'b1;
							res_q <= '{ST_WACK, '0, '0, '0, '0};
						end else if (in_item.op == OP_EVAL) begin
							state_q <= S_RDN;
						end
					end
				end
				S_RDN: state_q <= S_CHKN;
				S_CHKN: begin
					if (x_q > b_rd_q) begin
						res_v_q <= 1'b1;
						res_q <= '{ST_ABOVE, '0, '0, '0, '0};
						state_q <= S_IDLE;
					end else state_q <= S_CHK0;
				end
				S_CHK0: begin
					if (x_q < b_rd_q) begin
						res_v_q <= 1'b1;
						res_q <= '{ST_BELOW, '0, '0, '0, '0};
						state_q <= S_IDLE;
					end else state_q <= S_CHKC;
				end
				S_CHKC: begin
					hit_q <= (NW'(cache_q) < n_q) && (x_q > b_rd_q);
					k_q <= '0;
					state_q <= S_CHKC1;
				end
				S_CHKC1: begin
					hit_q <= 1'b0;
					if (hit_q && x_q < b_rd_q) begin
						seg_q <= cache_q;
						state_q <= S_DX;
					end else state_q <= S_SRCH;
				end
				S_SRCH: begin
					// b_rd_q holds the registered read of break[k_q]; hit_q makes each step wait for it
					if (hit_q) hit_q <= 1'b0;
					else if (NW'(k_q) < n_q && b_rd_q <= x_q) begin
						k_q <= k_q + 1'b1;
						hit_q <= 1'b1;
					end else begin
						seg_q <= (k_q == '0) ? '0 : SW'(k_q - 1'b1);
						cache_q <= (k_q == '0) ? '0 : SW'(k_q - 1'b1);
						state_q <= S_DX;
					end
				end
				S_DX: begin
					hit_q <= ~hit_q;
					if (hit_q) begin
						dx_q <= 33'(x_q) - 33'(b_rd_q);
						i_q <= '0;
						flag_q <= 1'b0;
						y0_q <= '0; y1_q <= '0; y2_q <= '0;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					hit_q <= ~hit_q;
					if (hit_q) begin
						c_q <= c_rd_q;
						mph_q <= 2'd0;
						state_q <= (i_q == '0) ? S_ADD : S_MUL;
					end
				end
				S_MUL: begin
					unique case (mph_q)
						2'd0: p0_q <= mul_r;
						2'd1: p1_q <= mul_r;
						default: p2_q <= mul_r;
					endcase
					mph_q <= mph_q + 1'b1;
					if (mph_q == 2'd2) state_q <= S_ADD;
				end
				S_ADD: begin
					y0_q <= ny0; y1_q <= ny1; y2_q <= ny2;
					flag_q <= nf;
					if (i_q == ord_q) begin
						res_v_q <= 1'b1;
						res_q <= '{nf ? ST_SAT : ST_OK, ny0, ny1, ny2, 8'(seg_q)};
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						hit_q <= 1'b0;
						state_q <= S_CRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PPE_ASSERT_NEXT(a_no_drop, clk, arst_n, res_v_q && out_stall, res_v_q && $stable(res_q))
	`PPE_ASSERT_IMPL(a_busy_stall, clk, arst_n, (state_q != S_IDLE) |-> in_stall)
	`PPE_ASSERT_NEXT(a_wr_ack, clk, arst_n, in_acc && in_item.op == OP_WR_BREAK, res_v_q && res_q.status == ST_WACK)
endmodule
